FILE: sv/tms_pkg.sv
// ----------------------------------------------------------------------------
// tms_pkg
// shared types and constants of the frame-timed micro-sequencer
// ----------------------------------------------------------------------------
package tms_pkg;

  // widths of the transaction fields
  localparam int IDX_W  = 6;
  localparam int WORD_W = 16;
  localparam int TAG_W  = 32;
  localparam int POS_W  = 13;

  // input modes
  localparam logic [1:0] MODE_WRITE  = 2'd0;
  localparam logic [1:0] MODE_COMMIT = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;

  // classified commands passed from front to back
  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_COMMIT = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  // instruction opcodes, word bits 15:13
  localparam logic [2:0] OP_AT      = 3'd1;
  localparam logic [2:0] OP_OFFSET  = 3'd2;
  localparam logic [2:0] OP_SYNCHRO = 3'd3;
  localparam logic [2:0] OP_MOVE    = 3'd4;
  localparam logic [2:0] OP_WAIT    = 3'd5;

  // result kinds
  localparam logic [1:0] KIND_MOVE    = 2'd0;
  localparam logic [1:0] KIND_SYNCHRO = 2'd1;
  localparam logic [1:0] KIND_OFFSET  = 2'd2;
  localparam logic [1:0] KIND_STATUS  = 2'd3;

  localparam int         FRAME_QBITS  = 5000;
  localparam int         MAX_RESULTS  = 64;
  localparam logic [4:0] DSP_IRQ_ADDR = 5'h10;
  localparam int         QUEUE_DEPTH  = 2;

  typedef struct packed {
    logic [1:0]        cmd;
    logic              idx_ok;
    logic [IDX_W-1:0]  windex;
    logic [WORD_W-1:0] word;
    logic [TAG_W-1:0]  tag;
  } cmd_t;

endpackage

FILE: sv/tms_ram.sv
// ----------------------------------------------------------------------------
// tms_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module tms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/tms_front.sv
// ----------------------------------------------------------------------------
// tms_front
// accepts input transactions, classifies them and registers the command
// ----------------------------------------------------------------------------
module tms_front #(
  parameter int RAM_WORDS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  mode,
  input  logic [tms_pkg::IDX_W-1:0]   word_index,
  input  logic [tms_pkg::WORD_W-1:0]  program_word,
  input  logic [tms_pkg::TAG_W-1:0]   frame_number,
  output logic                        q_valid,
  output tms_pkg::cmd_t               q_item,
  input  logic                        q_stall
);
  import tms_pkg::*;

  cmd_t cls;
  logic item_valid;

  always_comb begin
    case (mode)
      MODE_WRITE:  cls.cmd = CMD_WRITE;
      MODE_COMMIT: cls.cmd = CMD_COMMIT;
      MODE_TICK:   cls.cmd = CMD_TICK;
      default:     cls.cmd = CMD_NONE;
    endcase
    // writes past the end of program memory are dropped
    cls.idx_ok = {1'b0, word_index} < (IDX_W + 1)'(RAM_WORDS);
    cls.windex = word_index;
    cls.word   = program_word;
    cls.tag    = frame_number;
  end

  assign in_stall = item_valid & q_stall;
  assign q_valid  = item_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      q_item <= cls;
    end
  end

endmodule

FILE: sv/tms_queue.sv
// ----------------------------------------------------------------------------
// tms_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module tms_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_stall,
  input  tms_pkg::cmd_t push_item,
  output logic          pop_valid,
  output tms_pkg::cmd_t pop_item,
  input  logic          pop
);
  import tms_pkg::*;

  localparam int QP = $clog2(QUEUE_DEPTH);
  localparam int QC = $clog2(QUEUE_DEPTH + 1);

  cmd_t          entries [QUEUE_DEPTH];
  logic [QP-1:0] wr_ptr;
  logic [QP-1:0] rd_ptr;
  logic [QC-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_stall = (count == QC'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid & ~push_stall;
  assign do_pop     = pop & pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QP'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QP'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QC'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QC'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: sv/tms_back.sv
// ----------------------------------------------------------------------------
// tms_back
// sequencer: program store, snapshot copy, instruction walk, result register
// ----------------------------------------------------------------------------
module tms_back #(
  parameter int RAM_WORDS = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  input  tms_pkg::cmd_t              cmd,
  output logic                       cmd_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 kind,
  output logic [4:0]                 move_addr,
  output logic [7:0]                 move_data,
  output logic [12:0]                load_value,
  output logic                       dsp_irq,
  output logic [tms_pkg::TAG_W-1:0]  frame_tag,
  output logic [tms_pkg::POS_W-1:0]  qbit_pos,
  output logic [1:0]                 frames_left,
  output logic                       running,
  output logic                       last
);
  import tms_pkg::*;

  localparam int AW = $clog2(RAM_WORDS);
  localparam int PW = $clog2(RAM_WORDS + 1);
  localparam int CW = $clog2(MAX_RESULTS + 1);
  localparam logic [PW-1:0] RP_END   = PW'(RAM_WORDS);
  localparam logic [CW-1:0] CNT_HOLD = CW'(MAX_RESULTS - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(MAX_RESULTS);
  localparam logic [POS_W:0] Q1 = (POS_W + 1)'(FRAME_QBITS);
  localparam logic [POS_W:0] Q2 = (POS_W + 1)'(2 * FRAME_QBITS);
  localparam logic [POS_W:0] Q3 = (POS_W + 1)'(3 * FRAME_QBITS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_COPY  = 3'd1;
  localparam logic [2:0] ST_WALK  = 3'd2;
  localparam logic [2:0] ST_FETCH = 3'd3;
  localparam logic [2:0] ST_PEEK  = 3'd4;
  localparam logic [2:0] ST_FINAL = 3'd5;

  logic [2:0]       state;
  logic [PW-1:0]    rp;
  logic [POS_W-1:0] pos;
  logic [1:0]       pending;
  logic             active;
  logic [CW-1:0]    res_cnt;
  logic [TAG_W-1:0] tag;
  logic [RAM_WORDS-1:0] prog_valid;
  logic [PW-1:0]    copy_cnt;
  logic             copy_wr;
  logic [AW-1:0]    copy_wr_addr;

  // result held back when the list fills
  logic [1:0]  held_kind;
  logic [4:0]  held_addr;
  logic [7:0]  held_data;
  logic [12:0] held_load;
  logic        held_irq;

  // memory ports
  logic              prog_we;
  logic              prog_re;
  logic [WORD_W-1:0] prog_rd;
  logic              exec_we;
  logic [WORD_W-1:0] exec_wdata;
  logic              exec_re;
  logic [AW-1:0]     exec_raddr;
  logic [WORD_W-1:0] exec_rd;

  // decode
  logic [WORD_W-1:0] w;
  logic [2:0]        op;
  logic [12:0]       arg;
  logic [PW-1:0]     rp_inc;
  logic [POS_W:0]    sum;
  logic [POS_W:0]    fold_diff;
  logic [1:0]        fold_q;
  logic              is_action;
  logic [1:0]        act_kind;
  logic [4:0]        act_addr;
  logic [7:0]        act_data;
  logic [12:0]       act_load;
  logic              act_irq;
  logic              act_go;
  logic              act_emit;
  logic              act_hold;
  logic              fin_emit;
  logic              out_free;
  logic              walk_rd;
  logic              peek_rd;

  tms_ram #(.WIDTH(WORD_W), .DEPTH(RAM_WORDS)) u_prog_ram (
    .clk   (clk),
    .we    (prog_we),
    .waddr (cmd.windex[AW-1:0]),
    .wdata (cmd.word),
    .re    (prog_re),
    .raddr (copy_cnt[AW-1:0]),
    .rdata (prog_rd)
  );

  tms_ram #(.WIDTH(WORD_W), .DEPTH(RAM_WORDS)) u_exec_ram (
    .clk   (clk),
    .we    (exec_we),
    .waddr (copy_wr_addr),
    .wdata (exec_wdata),
    .re    (exec_re),
    .raddr (exec_raddr),
    .rdata (exec_rd)
  );

  always_comb begin
    w      = exec_rd;
    op     = w[15:13];
    arg    = w[12:0];
    rp_inc = rp + PW'(1);
    sum    = {1'b0, pos} + {1'b0, arg};
    if (sum >= Q3) begin
      fold_q    = 2'd3;
      fold_diff = sum - Q3;
    end else if (sum >= Q2) begin
      fold_q    = 2'd2;
      fold_diff = sum - Q2;
    end else begin
      fold_q    = 2'd1;
      fold_diff = sum - Q1;
    end

    is_action = (op == OP_SYNCHRO) || (op == OP_OFFSET) || (op == OP_MOVE);
    case (op)
      OP_SYNCHRO: act_kind = KIND_SYNCHRO;
      OP_OFFSET:  act_kind = KIND_OFFSET;
      default:    act_kind = KIND_MOVE;
    endcase
    act_addr = (op == OP_MOVE) ? w[4:0] : 5'd0;
    act_data = (op == OP_MOVE) ? w[12:5] : 8'd0;
    act_load = (op == OP_MOVE) ? 13'd0 : arg;
    act_irq  = (op == OP_MOVE) && (w[4:0] == DSP_IRQ_ADDR) && w[5];

    out_free = ~out_valid | ~out_stall;
    act_go   = (state == ST_FETCH) && (w != '0) && is_action &&
               ((res_cnt >= CNT_HOLD) || out_free);
    act_emit = act_go && (res_cnt < CNT_HOLD);
    act_hold = act_go && (res_cnt == CNT_HOLD);
    fin_emit = (state == ST_FINAL) && out_free;

    cmd_pop  = (state == ST_IDLE) && cmd_valid;
    prog_we  = cmd_pop && (cmd.cmd == CMD_WRITE) && cmd.idx_ok;
    prog_re  = (state == ST_COPY) && (copy_cnt < RP_END);

    exec_we    = (state == ST_COPY) && copy_wr;
    // words never written since reset read as zero
    exec_wdata = prog_valid[copy_wr_addr] ? prog_rd : '0;
    walk_rd    = (state == ST_WALK) && active && (rp < RP_END);
    peek_rd    = (state == ST_FETCH) && (w == '0) && (rp != '0) && (rp_inc < RP_END);
    exec_re    = walk_rd | peek_rd;
    exec_raddr = peek_rd ? rp_inc[AW-1:0] : rp[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rp         <= '0;
      pos        <= '0;
      pending    <= '0;
      active     <= 1'b0;
      res_cnt    <= '0;
      prog_valid <= '0;
      copy_cnt   <= '0;
      copy_wr    <= 1'b0;
    end else begin
      if (prog_we) begin
        prog_valid[cmd.windex[AW-1:0]] <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            res_cnt <= '0;
            case (cmd.cmd)
              CMD_COMMIT: begin
                rp       <= '0;
                pos      <= '0;
                pending  <= '0;
                active   <= 1'b1;
                copy_cnt <= '0;
                copy_wr  <= 1'b0;
                state    <= ST_COPY;
              end
              CMD_TICK: begin
                if (active && pending != '0) begin
                  pending <= pending - 2'd1;
                  state   <= (pending == 2'd1) ? ST_WALK : ST_FINAL;
                end else begin
                  state <= ST_FINAL;
                end
              end
              default: state <= ST_FINAL;
            endcase
          end
        end
        ST_COPY: begin
          copy_wr      <= prog_re;
          copy_wr_addr <= copy_cnt[AW-1:0];
          if (prog_re) begin
            copy_cnt <= copy_cnt + PW'(1);
          end else if (!copy_wr) begin
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (walk_rd) begin
            state <= ST_FETCH;
          end else begin
            active <= 1'b0;
            state  <= ST_FINAL;
          end
        end
        ST_FETCH: begin
          if (w == '0) begin
            if (rp == '0) begin
              rp    <= rp_inc;
              state <= ST_WALK;
            end else if (peek_rd) begin
              state <= ST_PEEK;
            end else begin
              // zero word at the end of memory stops the walk
              active <= 1'b0;
              state  <= ST_FINAL;
            end
          end else if (op == OP_AT) begin
            rp  <= rp_inc;
            pos <= arg;
            if (arg > pos) begin
              state <= ST_WALK;
            end else begin
              pending <= 2'd1;
              state   <= ST_FINAL;
            end
          end else if (op == OP_WAIT) begin
            rp <= rp_inc;
            if (sum >= Q1) begin
              pending <= fold_q;
              pos     <= fold_diff[POS_W-1:0];
              state   <= ST_FINAL;
            end else begin
              pos   <= sum[POS_W-1:0];
              state <= ST_WALK;
            end
          end else if (is_action) begin
            if (act_go) begin
              rp    <= rp_inc;
              state <= ST_WALK;
              if (res_cnt < CNT_FULL) begin
                res_cnt <= res_cnt + CW'(1);
              end
            end
          end else begin
            rp    <= rp_inc;
            state <= ST_WALK;
          end
        end
        ST_PEEK: begin
          if (w == '0) begin
            active <= 1'b0;
            state  <= ST_FINAL;
          end else begin
            rp    <= rp_inc;
            state <= ST_WALK;
          end
        end
        ST_FINAL: begin
          if (fin_emit) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      tag <= cmd.tag;
    end
    if (act_hold) begin
      held_kind <= act_kind;
      held_addr <= act_addr;
      held_data <= act_data;
      held_load <= act_load;
      held_irq  <= act_irq;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (act_emit || fin_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (act_emit) begin
      kind       <= act_kind;
      move_addr  <= act_addr;
      move_data  <= act_data;
      load_value <= act_load;
      dsp_irq    <= act_irq;
      last       <= 1'b0;
    end else if (fin_emit) begin
      if (res_cnt == CNT_FULL) begin
        kind       <= held_kind;
        move_addr  <= held_addr;
        move_data  <= held_data;
        load_value <= held_load;
        dsp_irq    <= held_irq;
      end else begin
        kind       <= KIND_STATUS;
        move_addr  <= '0;
        move_data  <= '0;
        load_value <= '0;
        dsp_irq    <= 1'b0;
      end
      last <= 1'b1;
    end
    if (act_emit || fin_emit) begin
      frame_tag   <= tag;
      qbit_pos    <= pos;
      frames_left <= pending;
      running     <= active;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    res_cnt <= CNT_FULL)
    else $error("result count past list size");

  a_ram_ports: assert property (@(posedge clk) disable iff (rst)
    !(prog_we && prog_re))
    else $error("program write during snapshot copy");

  a_stop_in_walk: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(active)) |->
      ($past(state) == ST_WALK || $past(state) == ST_FETCH ||
       $past(state) == ST_PEEK))
    else $error("walk stopped outside the walk states");

  a_pause_active: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && pending != 2'd0) |-> active)
    else $error("frames pending while stopped");
`endif

endmodule

FILE: sv/tdma_time_microsequencer.sv
// ----------------------------------------------------------------------------
// tdma_time_microsequencer
// frame-timed micro-sequencer: program store, commit snapshot and walk
// ----------------------------------------------------------------------------
// a write, a tick that resumes nothing, or an unused mode goes from idle
//   straight to the final state, which gives its status result
// a commit first copies program memory into the execution snapshot, then
//   walks the executed words (a zero word also looks at the next word
//   through the snapshot's single read port)
// one input is in the sequencer at a time; up to three more wait in front of
//   it, one in the front register and two in the queue
// reset clears the control state; program memory reads as zero through
//   per-word valid bits, so no clearing pass is needed
module tdma_time_microsequencer #(
  parameter int RAM_WORDS = 64
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [5:0]  word_index,
  input  logic [15:0] program_word,
  input  logic [31:0] frame_number,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [4:0]  move_addr,
  output logic [7:0]  move_data,
  output logic [12:0] load_value,
  output logic        dsp_irq,
  output logic [31:0] frame_tag,
  output logic [12:0] qbit_pos,
  output logic [1:0]  frames_left,
  output logic        running,
  output logic        last
);
  import tms_pkg::*;

  // classified command from the front stage
  logic front_valid;
  logic front_stall;
  cmd_t front_item;

  // head of the command queue
  logic q_valid;
  logic q_pop;
  cmd_t q_item;

  // front: takes one transaction per cycle while not stalled and decodes the mode
  tms_front #(.RAM_WORDS(RAM_WORDS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .word_index   (word_index),
    .program_word (program_word),
    .frame_number (frame_number),
    .q_valid      (front_valid),
    .q_item       (front_item),
    .q_stall      (front_stall)
  );

  // queue: lets the front keep accepting while the walk runs
  tms_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_stall (front_stall),
    .push_item  (front_item),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop        (q_pop)
  );

  // back: program writes, snapshot copy, instruction walk and results
  tms_back #(.RAM_WORDS(RAM_WORDS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (q_valid),
    .cmd         (q_item),
    .cmd_pop     (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .move_addr   (move_addr),
    .move_data   (move_data),
    .load_value  (load_value),
    .dsp_irq     (dsp_irq),
    .frame_tag   (frame_tag),
    .qbit_pos    (qbit_pos),
    .frames_left (frames_left),
    .running     (running),
    .last        (last)
  );

endmodule
